// ===== sv/bgc_pkg.sv =====
// bgc_pkg: shared constants, types and curve tables of the battery gauge
// used by the channel interfaces, the gauge top level and its checker
// depends on nothing
package bgc_pkg;

  localparam int TIME_BITS    = 48;
  localparam int MV_W         = 13;
  localparam int PCT_W        = 8;
  localparam int RAW_W        = 8;
  localparam int TTL_W        = 16;
  localparam int PROD_W       = 21;
  localparam int DIV_W        = 8;
  localparam int QUO_W        = 13;
  localparam int NUM_W        = 12;
  localparam int SEG_W        = 4;
  localparam int CNT_W        = 4;
  localparam int RISE_W       = 4;
  localparam int CFG_AW       = 4;
  localparam int CFG_DW       = 32;
  localparam int CURVE_POINTS = 12;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [RAW_W-1:0]  RAW_BAD       = 8'hFF;
  // 5600 = 21 * 255 + 245, whole part by shifts, fraction by the multiplier
  localparam logic [MV_W-1:0]   CONV_FRAC     = 13'd245;
  localparam logic [PROD_W-1:0] MV_ROUND      = 21'd127;
  localparam logic [MV_W-1:0]   CURVE_TOP_MV  = 13'd4200;
  localparam logic [MV_W-1:0]   CURVE_BOT_MV  = 13'd3300;

  localparam logic [CNT_W-1:0] INTERP_ITERS = 4'd12;

  localparam logic signed [PCT_W-1:0] PCT_FULL  = 8'sd100;
  localparam logic signed [PCT_W-1:0] PCT_EMPTY = 8'sd0;
  localparam logic signed [PCT_W-1:0] PCT_NONE  = -8'sd1;

  localparam logic [MV_W-1:0]  VALID_MIN_RST  = 13'd3000;
  localparam logic [MV_W-1:0]  VALID_MAX_RST  = 13'd4500;
  localparam logic [TTL_W-1:0] CACHE_TTL_RST  = 16'd5000;
  localparam logic [TTL_W-1:0] RETRY_COOL_RST = 16'd1000;

  typedef enum logic [1:0] {
    REG_VALID_MIN  = 2'd0,
    REG_VALID_MAX  = 2'd1,
    REG_CACHE_TTL  = 2'd2,
    REG_RETRY_COOL = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CONV_MUL,
    ST_CONV_FOLD,
    ST_CHECK,
    ST_INTERP_MUL,
    ST_INTERP_LOAD,
    ST_INTERP_DIV,
    ST_FINISH
  } bgc_state_t;

  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      4'd0:    v = 13'd4200;
      4'd1:    v = 13'd4060;
      4'd2:    v = 13'd3980;
      4'd3:    v = 13'd3920;
      4'd4:    v = 13'd3870;
      4'd5:    v = 13'd3820;
      4'd6:    v = 13'd3790;
      4'd7:    v = 13'd3770;
      4'd8:    v = 13'd3740;
      4'd9:    v = 13'd3680;
      4'd10:   v = 13'd3450;
      4'd11:   v = 13'd3300;
      default: v = 13'd3300;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-2:0] curve_pct(input logic [SEG_W-1:0] idx);
    logic [PCT_W-2:0] v;
    case (idx)
      4'd0:    v = 7'd100;
      4'd1:    v = 7'd90;
      4'd2:    v = 7'd80;
      4'd3:    v = 7'd70;
      4'd4:    v = 7'd60;
      4'd5:    v = 7'd50;
      4'd6:    v = 7'd40;
      4'd7:    v = 7'd30;
      4'd8:    v = 7'd20;
      4'd9:    v = 7'd10;
      4'd10:   v = 7'd5;
      4'd11:   v = 7'd0;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DIV_W-1:0] span_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] d;
    d = curve_mv(idx - 4'd1) - curve_mv(idx);
    return d[DIV_W-1:0];
  endfunction

  function automatic logic [RISE_W-1:0] seg_rise(input logic [SEG_W-1:0] idx);
    logic [PCT_W-2:0] d;
    d = curve_pct(idx - 4'd1) - curve_pct(idx);
    return d[RISE_W-1:0];
  endfunction

endpackage

// ===== sv/bgc_if.sv =====
// bgc_in_if / bgc_out_if: valid-ready channels of the battery gauge
// request beat carries action and sample fields, result beat the gauge answer
// depends on bgc_pkg
interface bgc_in_if import bgc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [TIME_BITS-1:0] now_ms;
  logic [RAW_W-1:0]     raw_code;
  logic                 read_ok;

  modport source (output valid, action, now_ms, raw_code, read_ok, input ready);
  modport sink   (input valid, action, now_ms, raw_code, read_ok, output ready);
endinterface

interface bgc_out_if import bgc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PCT_W-1:0] percent;
  logic                    need_sample;
  logic [MV_W-1:0]         millivolts;
  logic                    from_cache;

  modport source (output valid, percent, need_sample, millivolts, from_cache, input ready);
  modport sink   (input valid, percent, need_sample, millivolts, from_cache, output ready);
endinterface

// ===== sv/battery_gauge_with_cache.sv =====
// battery_gauge_with_cache: lipo state-of-charge gauge with a one-entry level cache
// depends on bgc_pkg, bgc_in_if, bgc_out_if
//
// One request beat at a time. A query (action 0) is answered from the cached level while
// it exists and now_ms is before the cache deadline, else it returns -1 with need_sample
// set; a query or a failed read goes from decode straight to the finish state. A sample
// (action 1) turns the raw code into millivolts with one multiply and a shift-and-add fold
// by 255, checks it against the plausible range and interpolates the percent on a 12-point
// curve. The interpolation reuses the shared multiplier and one radix-2 restoring divider
// by the segment width that retires one quotient bit a cycle over 12 divider steps; a
// rejected or end-of-curve reading goes from the check straight to the finish state.
// The result sits in an output register, so a new request is taken while the previous
// result waits; a finished result then holds in the sequencer until that register frees.
// Config registers at byte offsets 0x0, 0x4, 0x8, 0xC; write them only while idle.
module battery_gauge_with_cache import bgc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bgc_in_if.sink            in_ch,
  bgc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  bgc_state_t state_r, state_nxt;

  logic [MV_W-1:0]  valid_min_r, valid_max_r;
  logic [TTL_W-1:0] cache_ttl_r, retry_cool_r;

  logic signed [PCT_W-1:0] cached_level_r;
  logic [TIME_BITS-1:0]    deadline_r;

  logic                 action_r;
  logic [TIME_BITS-1:0] now_r;
  logic [RAW_W-1:0]     raw_r;
  logic                 ok_r;

  logic signed [PCT_W-1:0] pct_r;
  logic                    need_r;
  logic                    hit_r;
  logic                    good_r;
  logic [MV_W-1:0]         mv_r;
  logic [SEG_W-1:0]        seg_r;

  logic [PROD_W-1:0] prod_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [PROD_W-1:0] dvd_r;
  logic [QUO_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;

  logic                    out_valid_r;
  logic signed [PCT_W-1:0] out_pct_r;
  logic                    out_need_r;
  logic [MV_W-1:0]         out_mv_r;
  logic                    out_hit_r;

  logic                    cfg_wr;
  logic                    in_fire;
  logic                    out_free;
  logic                    div_last;
  logic                    cache_hit;
  logic                    mv_good;
  logic [SEG_W-1:0]        seg_find;
  logic [MV_W-1:0]         mul_a, mul_b;
  logic [2*MV_W-1:0]       mul_p;
  logic [PROD_W-1:0]       conv_x;
  logic [PROD_W-1:0]       conv_fold;
  logic [MV_W-1:0]         conv_whole;
  logic [MV_W-1:0]         conv_mv;
  logic [MV_W-1:0]         interp_diff;
  logic [DIV_W:0]          step_t;
  logic [DIV_W:0]          step_d;
  logic                    step_ge;
  logic [PCT_W-2:0]        quo_step;
  logic [PCT_W-1:0]        interp_sum;
  logic signed [PCT_W-1:0] interp_pct;
  logic [TTL_W-1:0]        delay;
  logic [TIME_BITS:0]      dl_sum;
  logic [TIME_BITS-1:0]    dl_sat;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_min_r  <= VALID_MIN_RST;
      valid_max_r  <= VALID_MAX_RST;
      cache_ttl_r  <= CACHE_TTL_RST;
      retry_cool_r <= RETRY_COOL_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_VALID_MIN:  valid_min_r  <= pwdata[MV_W-1:0];
        REG_VALID_MAX:  valid_max_r  <= pwdata[MV_W-1:0];
        REG_CACHE_TTL:  cache_ttl_r  <= pwdata[TTL_W-1:0];
        REG_RETRY_COOL: retry_cool_r <= pwdata[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_VALID_MIN:  prdata = {{(CFG_DW-MV_W){1'b0}}, valid_min_r};
      REG_VALID_MAX:  prdata = {{(CFG_DW-MV_W){1'b0}}, valid_max_r};
      REG_CACHE_TTL:  prdata = {{(CFG_DW-TTL_W){1'b0}}, cache_ttl_r};
      REG_RETRY_COOL: prdata = {{(CFG_DW-TTL_W){1'b0}}, retry_cool_r};
      default:        prdata = '0;
    endcase
  end

  // handshakes
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign div_last = (cnt_r == 4'd1);

  // shared multiplier
  assign interp_diff = mv_r - curve_mv(seg_r);

  always_comb begin
    if (state_r == ST_INTERP_MUL) begin
      mul_a = {{(MV_W-DIV_W){1'b0}}, interp_diff[DIV_W-1:0]};
      mul_b = {{(MV_W-RISE_W){1'b0}}, seg_rise(seg_r)};
    end else begin
      mul_a = {{(MV_W-RAW_W){1'b0}}, raw_r};
      mul_b = CONV_FRAC;
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign conv_x = mul_p[PROD_W-1:0] + MV_ROUND;

  // divide by 255: (y + 1 + (y >> 8)) >> 8, exact while y stays below 65535
  assign conv_fold  = prod_r + PROD_W'(1) + {{RAW_W{1'b0}}, prod_r[PROD_W-1:RAW_W]};
  assign conv_whole = {{(MV_W-RAW_W-4){1'b0}}, raw_r, 4'b0} +
                      {{(MV_W-RAW_W-2){1'b0}}, raw_r, 2'b0} +
                      {{(MV_W-RAW_W){1'b0}}, raw_r};
  assign conv_mv    = conv_whole + {{(MV_W-RAW_W){1'b0}}, conv_fold[2*RAW_W-1:RAW_W]};

  // divider step
  assign step_t  = {rem_r, dvd_r[PROD_W-1]};
  assign step_d  = step_t - {1'b0, dsr_r};
  assign step_ge = (step_t >= {1'b0, dsr_r});

  // decisions
  assign cache_hit = ~cached_level_r[PCT_W-1] & (now_r < deadline_r);
  assign mv_good   = (raw_r != RAW_BAD) & (quo_r >= valid_min_r) & (quo_r <= valid_max_r);

  always_comb begin
    seg_find = SEG_W'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (quo_r >= curve_mv(SEG_W'(i))) seg_find = SEG_W'(i);
    end
  end

  // quotient including the bit retired this cycle
  assign quo_step   = {quo_r[PCT_W-3:0], step_ge};
  assign interp_sum = {1'b0, curve_pct(seg_r)} + {1'b0, quo_step};
  assign interp_pct = (interp_sum > PCT_FULL) ? PCT_FULL : interp_sum;

  // deadline update
  assign delay  = good_r ? cache_ttl_r : retry_cool_r;
  assign dl_sum = {1'b0, now_r} + {{(TIME_BITS+1-TTL_W){1'b0}}, delay};
  assign dl_sat = dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (action_r && ok_r) state_nxt = ST_CONV_MUL;
        else state_nxt = ST_FINISH;
      end
      ST_CONV_MUL:  state_nxt = ST_CONV_FOLD;
      ST_CONV_FOLD: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (mv_good && (quo_r < CURVE_TOP_MV) && (quo_r > CURVE_BOT_MV)) begin
          state_nxt = ST_INTERP_MUL;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_INTERP_MUL:  state_nxt = ST_INTERP_LOAD;
      ST_INTERP_LOAD: state_nxt = ST_INTERP_DIV;
      ST_INTERP_DIV: begin
        if (div_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= in_ch.action;
      now_r    <= in_ch.now_ms;
      raw_r    <= in_ch.raw_code;
      ok_r     <= in_ch.read_ok;
    end
    case (state_r)
      ST_DECODE: begin
        mv_r   <= '0;
        good_r <= 1'b0;
        if (!action_r) begin
          hit_r  <= cache_hit;
          need_r <= ~cache_hit;
          pct_r  <= cache_hit ? cached_level_r : PCT_NONE;
        end else begin
          hit_r  <= 1'b0;
          need_r <= 1'b0;
          pct_r  <= PCT_NONE;
        end
      end
      ST_CONV_MUL:  prod_r <= conv_x;
      ST_CONV_FOLD: quo_r  <= conv_mv;
      ST_INTERP_DIV: begin
        rem_r <= step_ge ? step_d[DIV_W-1:0] : step_t[DIV_W-1:0];
        dvd_r <= {dvd_r[PROD_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], step_ge};
        cnt_r <= cnt_r - 4'd1;
        if (div_last) begin
          pct_r <= interp_pct;
        end
      end
      ST_CHECK: begin
        mv_r   <= quo_r;
        good_r <= mv_good;
        seg_r  <= seg_find;
        if (!mv_good) pct_r <= PCT_NONE;
        else if (quo_r >= CURVE_TOP_MV) pct_r <= PCT_FULL;
        else pct_r <= PCT_EMPTY;
      end
      ST_INTERP_MUL: prod_r <= mul_p[PROD_W-1:0];
      ST_INTERP_LOAD: begin
        rem_r <= '0;
        dvd_r <= {prod_r[NUM_W-1:0], {(PROD_W-NUM_W){1'b0}}};
        dsr_r <= span_mv(seg_r);
        quo_r <= '0;
        cnt_r <= INTERP_ITERS;
      end
      default: ;
    endcase
  end

  // cache state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_level_r <= PCT_NONE;
      deadline_r     <= '0;
    end else if (state_r == ST_FINISH && out_free && action_r) begin
      deadline_r <= dl_sat;
      if (good_r) cached_level_r <= pct_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_pct_r  <= pct_r;
      out_need_r <= need_r;
      out_mv_r   <= mv_r;
      out_hit_r  <= hit_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.percent     = out_pct_r;
  assign out_ch.need_sample = out_need_r;
  assign out_ch.millivolts  = out_mv_r;
  assign out_ch.from_cache  = out_hit_r;

endmodule

// ===== sv/bgc_checker.sv =====
// bgc_checker: port-level assertions for the battery gauge, bound to the top level
// watches the request and result channels only
// depends on bgc_pkg and battery_gauge_with_cache
module bgc_checker import bgc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [PCT_W-1:0] out_percent,
  input logic                    out_need_sample,
  input logic [MV_W-1:0]         out_millivolts,
  input logic                    out_from_cache
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_percent) &&
      $stable(out_need_sample) && $stable(out_millivolts) && $stable(out_from_cache))
    else $error("result beat changed while stalled");

  // one request beat at a time
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // cache hit carries a real level and no voltage
  a_hit_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_from_cache |->
      !out_need_sample && out_millivolts == '0 && !out_percent[PCT_W-1] &&
      out_percent <= PCT_FULL)
    else $error("bad cache hit beat");

  // miss asks for a sample with no level
  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_need_sample |->
      out_percent == PCT_NONE && out_millivolts == '0 && !out_from_cache)
    else $error("bad cache miss beat");

endmodule

bind battery_gauge_with_cache bgc_checker u_bgc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_percent     (out_ch.percent),
  .out_need_sample (out_ch.need_sample),
  .out_millivolts  (out_ch.millivolts),
  .out_from_cache  (out_ch.from_cache)
);

// ===== tb/battery_gauge_with_cache_test.sv =====
`timescale 1ns / 100ps
// battery_gauge_with_cache_test: self-checking bench for the battery gauge with level cache
// request/result beats are checked against an in-bench gauge predictor held in a scoreboard
// depends on bgc_pkg, bgc_in_if, bgc_out_if, battery_gauge_with_cache
import bgc_pkg::*;

localparam logic ACT_QUERY  = 1'b0;
localparam logic ACT_SAMPLE = 1'b1;

typedef struct {
  logic                 action;
  logic [TIME_BITS-1:0] now_ms;
  logic [RAW_W-1:0]     raw_code;
  logic                 read_ok;
} gauge_req_t;

typedef struct {
  logic signed [PCT_W-1:0] percent;
  logic                    need_sample;
  logic [MV_W-1:0]         millivolts;
  logic                    from_cache;
} gauge_ans_t;

class gauge_scoreboard;
  int unsigned             min_mv, max_mv, ttl_ms, cool_ms;
  logic signed [PCT_W-1:0] level;
  logic [TIME_BITS-1:0]    deadline;
  gauge_ans_t              answers_due[$];
  int                      errors;
  int unsigned knee_mv[12]  = '{4200, 4060, 3980, 3920, 3870, 3820, 3790, 3770, 3740, 3680,
                                3450, 3300};
  int unsigned knee_pct[12] = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5, 0};

  function new();
    min_mv   = VALID_MIN_RST;
    max_mv   = VALID_MAX_RST;
    ttl_ms   = CACHE_TTL_RST;
    cool_ms  = RETRY_COOL_RST;
    level    = PCT_NONE;
    deadline = '0;
    errors   = 0;
  endfunction

  function void set_register(reg_idx_t idx, int unsigned value);
    case (idx)
      REG_VALID_MIN:  min_mv  = value & 32'h1FFF;
      REG_VALID_MAX:  max_mv  = value & 32'h1FFF;
      REG_CACHE_TTL:  ttl_ms  = value & 32'hFFFF;
      REG_RETRY_COOL: cool_ms = value & 32'hFFFF;
      default: ;
    endcase
  endfunction

  function int unsigned percent_of(int unsigned mv);
    if (mv >= knee_mv[0]) return 100;
    if (mv <= knee_mv[11]) return 0;
    for (int i = 1; i < 12; i++) begin
      if (mv >= knee_mv[i])
        return knee_pct[i] + (mv - knee_mv[i]) * (knee_pct[i-1] - knee_pct[i]) /
               (knee_mv[i-1] - knee_mv[i]);
    end
    return 0;
  endfunction

  function logic [TIME_BITS-1:0] push_deadline(logic [TIME_BITS-1:0] now,
                                               int unsigned delay);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, now} + {17'd0, delay};
    return (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

  function void note_request(gauge_req_t r);
    gauge_ans_t  a;
    int unsigned mv;
    bit          good;
    a.percent     = PCT_NONE;
    a.need_sample = 1'b0;
    a.millivolts  = '0;
    a.from_cache  = 1'b0;
    if (r.action == ACT_QUERY) begin
      if (level >= 0 && r.now_ms < deadline) begin
        a.percent    = level;
        a.from_cache = 1'b1;
      end else begin
        a.need_sample = 1'b1;
      end
    end else begin
      mv   = 0;
      good = 1'b0;
      if (r.read_ok) begin
        mv   = (int'(r.raw_code) * 5600 + 127) / 255;
        good = r.raw_code != RAW_BAD && mv >= min_mv && mv <= max_mv;
      end
      a.millivolts = mv[MV_W-1:0];
      if (good) begin
        a.percent = PCT_W'(percent_of(mv));
        level     = a.percent;
        deadline  = push_deadline(r.now_ms, ttl_ms);
      end else begin
        deadline = push_deadline(r.now_ms, cool_ms);
      end
    end
    answers_due.push_back(a);
  endfunction

  function int pending();
    return answers_due.size();
  endfunction

  function void check_result(logic signed [PCT_W-1:0] pct, logic need, logic [MV_W-1:0] mv,
                             logic hit);
    gauge_ans_t want;
    if (answers_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result beat with nothing pending: pct %0d need %0b mv %0d hit %0b",
                 pct, need, mv, hit);
      return;
    end
    want = answers_due.pop_front();
    if (pct !== want.percent || need !== want.need_sample || mv !== want.millivolts ||
        hit !== want.from_cache) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp pct %0d need %0b mv %0d hit %0b, got pct %0d need %0b mv %0d hit %0b",
                 want.percent, want.need_sample, want.millivolts, want.from_cache,
                 pct, need, mv, hit);
    end
  endfunction
endclass

module battery_gauge_with_cache_test;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PHASES           = 7;
  localparam int RANDOM_PER_PHASE = 105;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  bgc_in_if  in_ch ();
  bgc_out_if out_ch ();

  gauge_scoreboard      board;
  int                   send_idle_pct, stall_pct, cycles;
  logic [TIME_BITS-1:0] clock_ms;

  battery_gauge_with_cache dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  task automatic send_request(gauge_req_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= r.action;
    in_ch.now_ms   <= r.now_ms;
    in_ch.raw_code <= r.raw_code;
    in_ch.read_ok  <= r.read_ok;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(r);
  endtask

  task automatic send_fields(logic act, logic [TIME_BITS-1:0] now, logic [RAW_W-1:0] raw,
                             logic ok);
    gauge_req_t r;
    r.action   = act;
    r.now_ms   = now;
    r.raw_code = raw;
    r.read_ok  = ok;
    send_request(r);
  endtask

  task automatic write_register(reg_idx_t idx, int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid and hold off until every result beat is back
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic gauge_req_t random_request();
    gauge_req_t r;
    int         roll, pace;
    roll = $urandom_range(0, 99);
    pace = $urandom_range(0, 9);
    if (pace < 6)      clock_ms = clock_ms + 48'($urandom_range(0, 200));
    else if (pace < 9) clock_ms = clock_ms + 48'($urandom_range(0, 6000));
    else               clock_ms = clock_ms + 48'($urandom_range(0, 70000));
    r.action   = ACT_SAMPLE;
    r.now_ms   = clock_ms;
    r.raw_code = 8'($urandom_range(125, 215));
    r.read_ok  = $urandom_range(0, 9) != 0;
    if (roll >= 45 && roll < 85) begin
      r.action   = ACT_QUERY;
      r.raw_code = 8'($urandom);
      r.read_ok  = 1'($urandom);
    end else if (roll >= 85 && roll < 95) begin
      r.raw_code = 8'($urandom);
      r.read_ok  = 1'($urandom);
    end else if (roll >= 95) begin
      r.action   = 1'($urandom);
      r.raw_code = 8'($urandom);
      r.read_ok  = 1'($urandom);
      if ($urandom_range(0, 1) == 0) r.now_ms = {16'($urandom), $urandom};
      else                           r.now_ms = TIME_MAX - 48'($urandom_range(0, 70000));
    end
    return r;
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result(out_ch.percent, out_ch.need_sample, out_ch.millivolts,
                         out_ch.from_cache);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned min_mv, max_mv, ttl_ms, cool_ms;
    board          = new();
    send_idle_pct  = 0;
    stall_pct      = 0;
    clock_ms       = '0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_QUERY;
    in_ch.now_ms   = '0;
    in_ch.raw_code = '0;
    in_ch.read_ok  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph > 0) begin
        case (ph)
          1:       begin min_mv = 0;    max_mv = 5600; ttl_ms = 65535; cool_ms = 0;     end
          2:       begin min_mv = 3500; max_mv = 4000; ttl_ms = 0;     cool_ms = 65535; end
          3:       begin min_mv = 5600; max_mv = 0;    ttl_ms = 2000;  cool_ms = 500;   end
          4:       begin
            min_mv  = $urandom_range(2800, 3600);
            max_mv  = $urandom_range(3900, 5600);
            ttl_ms  = $urandom_range(0, 20000);
            cool_ms = $urandom_range(0, 5000);
          end
          5:       begin min_mv = 0;    max_mv = 0;    ttl_ms = 65535; cool_ms = 65535; end
          default: begin min_mv = 3000; max_mv = 4500; ttl_ms = 5000;  cool_ms = 1000;  end
        endcase
        write_register(REG_VALID_MIN, min_mv);
        write_register(REG_VALID_MAX, max_mv);
        write_register(REG_CACHE_TTL, ttl_ms);
        write_register(REG_RETRY_COOL, cool_ms);
      end
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 56; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      if (ph == 0) begin
        // empty cache, failed and implausible reads
        send_fields(ACT_QUERY,  48'd0, 8'h00, 1'b0);
        send_fields(ACT_SAMPLE, 48'd5, 8'hAB, 1'b0);
        send_fields(ACT_QUERY,  48'd6, 8'hFF, 1'b1);
        send_fields(ACT_SAMPLE, 48'd7, RAW_BAD, 1'b1);
        send_fields(ACT_SAMPLE, 48'd8, 8'h00, 1'b1);
        // fill, hit, expire exactly at the deadline
        send_fields(ACT_SAMPLE, 48'd100, 8'd192, 1'b1);
        send_fields(ACT_QUERY,  48'd5099, 8'h00, 1'b0);
        send_fields(ACT_QUERY,  48'd5100, 8'h00, 1'b0);
        // curve bottom, interpolation, old level kept across a failed read
        send_fields(ACT_SAMPLE, 48'd6000, 8'd150, 1'b1);
        send_fields(ACT_SAMPLE, 48'd6001, 8'd172, 1'b1);
        send_fields(ACT_SAMPLE, 48'd6002, 8'd172, 1'b0);
        send_fields(ACT_QUERY,  48'd6003, 8'h00, 1'b0);
        // plausible range edges
        send_fields(ACT_SAMPLE, 48'd7000, 8'd137, 1'b1);
        send_fields(ACT_SAMPLE, 48'd7001, 8'd136, 1'b1);
        send_fields(ACT_SAMPLE, 48'd7002, 8'd204, 1'b1);
        send_fields(ACT_SAMPLE, 48'd7003, 8'd205, 1'b1);
        send_fields(ACT_SAMPLE, 48'd8000, 8'd180, 1'b1);
        send_fields(ACT_SAMPLE, 48'd8001, 8'd160, 1'b1);
        // deadline saturation at the top of the time range
        send_fields(ACT_SAMPLE, TIME_MAX - 48'd100, 8'd167, 1'b1);
        send_fields(ACT_QUERY,  TIME_MAX - 48'd1, 8'h00, 1'b0);
        send_fields(ACT_QUERY,  TIME_MAX, 8'h00, 1'b0);
        send_fields(ACT_SAMPLE, TIME_MAX, 8'h00, 1'b0);
        send_fields(ACT_QUERY,  48'd12, 8'h00, 1'b0);
      end
      clock_ms = 48'($urandom);
      repeat (RANDOM_PER_PHASE) send_request(random_request());
    end

    settle();
    repeat (64) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== battery_gauge_with_cache.f =====
sv/bgc_pkg.sv
sv/bgc_if.sv
sv/battery_gauge_with_cache.sv
sv/bgc_checker.sv
tb/battery_gauge_with_cache_test.sv
